>>> rtl/core/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle implication violated");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle implication violated");

`endif

>>> rtl/core/adsr_pkg.sv
// types and constants of the adsr envelope generator
`default_nettype none

package adsr_pkg;

   localparam int TIME_W     = 32;
   localparam int LEVEL_W    = 16;
   localparam int LEVEL_FRAC = 15;
   localparam int PROD_W     = TIME_W + LEVEL_W;
   localparam int DIV_STEPS  = LEVEL_W;
   localparam int CNT_W      = $clog2(DIV_STEPS);
   localparam int CSR_IDX_W  = 3;

   localparam logic [LEVEL_W-1:0] LEVEL_ONE   = LEVEL_W'(1 << LEVEL_FRAC);
   localparam logic [LEVEL_W-1:0] LEVEL_FLOOR = LEVEL_W'((1 << LEVEL_FRAC) / 10000);

   localparam logic [1:0] MODE_SAMPLE = 2'd0;
   localparam logic [1:0] MODE_ON     = 2'd1;
   localparam logic [1:0] MODE_OFF    = 2'd2;

   localparam logic [1:0] STAGE_ATTACK  = 2'd0;
   localparam logic [1:0] STAGE_DECAY   = 2'd1;
   localparam logic [1:0] STAGE_SUSTAIN = 2'd2;
   localparam logic [1:0] STAGE_RELEASE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SUSTAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START   = 3'd4;

   localparam logic [TIME_W-1:0]  RST_ATTACK  = 32'd655;
   localparam logic [TIME_W-1:0]  RST_DECAY   = 32'd65536;
   localparam logic [TIME_W-1:0]  RST_RELEASE = 32'd65536;
   localparam logic [LEVEL_W-1:0] RST_SUSTAIN = 16'd0;
   localparam logic [LEVEL_W-1:0] RST_START   = 16'd32768;

   typedef struct packed {
      logic [TIME_W-1:0]  attack_time;
      logic [TIME_W-1:0]  decay_time;
      logic [TIME_W-1:0]  release_time;
      logic [LEVEL_W-1:0] sustain_level;
      logic [LEVEL_W-1:0] start_level;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [TIME_W-1:0] now;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] amplitude;
      logic [1:0]         stage;
   } rsp_type;

   typedef struct packed {
      logic idle;
      logic done;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/core/adsr_core.sv
// envelope sequencer with shared subtractor, multiplier and restoring divider
`default_nettype none

module adsr_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  adsr_pkg::req_type    req,
   input  adsr_pkg::cfg_type    cfg,
   input  logic                 take,
   output adsr_pkg::status_type status,
   output adsr_pkg::rsp_type    result
);
   import adsr_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_LIFE = 7'b0000010,
      ST_ATK  = 7'b0000100,
      ST_DEC  = 7'b0001000,
      ST_MUL  = 7'b0010000,
      ST_DIV  = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   logic                 held_ff, held_in;
   logic [TIME_W-1:0]    on_ff, on_in;
   logic [TIME_W-1:0]    off_ff, off_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic [TIME_W-1:0]    diff_ff, diff_in;
   logic [1:0]           stage_ff, stage_in;
   logic [TIME_W-1:0]    mul_a_ff, mul_a_in;
   logic [LEVEL_W-1:0]   mul_b_ff, mul_b_in;
   logic [TIME_W-1:0]    div_d_ff, div_d_in;
   logic [LEVEL_W-1:0]   base_ff, base_in;
   logic                 sub_ff, sub_in;
   logic [TIME_W-1:0]    rem_ff, rem_in;
   logic [LEVEL_W-1:0]   low_ff, low_in;
   logic [LEVEL_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   logic [TIME_W-1:0]    attack_dur, decay_dur, release_dur;
   logic [LEVEL_W-1:0]   sus_lvl, peak_lvl;
   logic [TIME_W:0]      alu_x, alu_y;
   logic [TIME_W+1:0]    alu_res;
   logic                 alu_borrow, alu_zero;
   logic [PROD_W-1:0]    product;
   logic [LEVEL_W:0]     lvl_sum;
   logic [LEVEL_W-1:0]   amp_out;

   // zero duration acts as one, levels clamp at one
   assign attack_dur  = (cfg.attack_time  == '0) ? TIME_W'(1) : cfg.attack_time;
   assign decay_dur   = (cfg.decay_time   == '0) ? TIME_W'(1) : cfg.decay_time;
   assign release_dur = (cfg.release_time == '0) ? TIME_W'(1) : cfg.release_time;
   assign sus_lvl  = (cfg.sustain_level > LEVEL_ONE) ? LEVEL_ONE : cfg.sustain_level;
   assign peak_lvl = (cfg.start_level   > LEVEL_ONE) ? LEVEL_ONE : cfg.start_level;

   // shared subtractor
   always_comb begin
      alu_x = '0;
      alu_y = '0;
      case (state_ff)
         ST_LIFE: begin
            alu_x = {1'b0, now_ff};
            alu_y = {1'b0, held_ff ? on_ff : off_ff};
         end
         ST_ATK: begin
            alu_x = {1'b0, diff_ff};
            alu_y = {1'b0, held_ff ? attack_dur : release_dur};
         end
         ST_DEC: begin
            alu_x = {1'b0, decay_dur};
            alu_y = {1'b0, diff_ff};
         end
         ST_DIV: begin
            alu_x = {rem_ff, low_ff[LEVEL_W-1]};
            alu_y = {1'b0, div_d_ff};
         end
         default: begin
            alu_x = '0;
            alu_y = '0;
         end
      endcase
   end

   assign alu_res    = {1'b0, alu_x} - {1'b0, alu_y};
   assign alu_borrow = alu_res[TIME_W+1];
   assign alu_zero   = (alu_res[TIME_W:0] == '0);

   assign product = PROD_W'(mul_a_ff) * PROD_W'(mul_b_ff);

   assign lvl_sum = sub_ff ? ({1'b0, base_ff} - {1'b0, quo_ff})
                           : ({1'b0, base_ff} + {1'b0, quo_ff});
   assign amp_out = (lvl_sum <= {1'b0, LEVEL_FLOOR}) ? '0 : lvl_sum[LEVEL_W-1:0];

   always_comb begin
      state_in = state_ff;
      held_in  = held_ff;
      on_in    = on_ff;
      off_in   = off_ff;
      now_in   = now_ff;
      diff_in  = diff_ff;
      stage_in = stage_ff;
      mul_a_in = mul_a_ff;
      mul_b_in = mul_b_ff;
      div_d_in = div_d_ff;
      base_in  = base_ff;
      sub_in   = sub_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               now_in   = req.now;
               state_in = ST_LIFE;
               if (req.mode == MODE_ON) begin
                  on_in   = req.now;
                  held_in = 1'b1;
               end else if (req.mode == MODE_OFF) begin
                  off_in  = req.now;
                  held_in = 1'b0;
               end
            end
         end
         ST_LIFE: begin
            if (alu_borrow) begin
               // before the trigger
               mul_a_in = '0;
               mul_b_in = '0;
               div_d_in = attack_dur;
               base_in  = '0;
               sub_in   = 1'b0;
               stage_in = held_ff ? STAGE_ATTACK : STAGE_RELEASE;
               state_in = ST_MUL;
            end else begin
               diff_in  = alu_res[TIME_W-1:0];
               state_in = ST_ATK;
            end
         end
         ST_ATK: begin
            if (held_ff) begin
               if (alu_borrow || alu_zero) begin
                  mul_a_in = diff_ff;
                  mul_b_in = peak_lvl;
                  div_d_in = attack_dur;
                  base_in  = '0;
                  sub_in   = 1'b0;
                  stage_in = STAGE_ATTACK;
                  state_in = ST_MUL;
               end else begin
                  diff_in  = alu_res[TIME_W-1:0];
                  state_in = ST_DEC;
               end
            end else begin
               stage_in = STAGE_RELEASE;
               div_d_in = release_dur;
               state_in = ST_MUL;
               if (!alu_borrow) begin
                  // release finished
                  mul_a_in = '0;
                  mul_b_in = '0;
                  base_in  = '0;
                  sub_in   = 1'b0;
               end else begin
                  mul_a_in = diff_ff;
                  mul_b_in = sus_lvl;
                  base_in  = sus_lvl;
                  sub_in   = 1'b1;
               end
            end
         end
         ST_DEC: begin
            div_d_in = decay_dur;
            state_in = ST_MUL;
            if (!alu_borrow) begin
               mul_a_in = diff_ff;
               base_in  = peak_lvl;
               stage_in = STAGE_DECAY;
               if (sus_lvl >= peak_lvl) begin
                  mul_b_in = sus_lvl - peak_lvl;
                  sub_in   = 1'b0;
               end else begin
                  mul_b_in = peak_lvl - sus_lvl;
                  sub_in   = 1'b1;
               end
            end else begin
               mul_a_in = '0;
               mul_b_in = '0;
               base_in  = sus_lvl;
               sub_in   = 1'b0;
               stage_in = STAGE_SUSTAIN;
            end
         end
         ST_MUL: begin
            rem_in   = product[PROD_W-1:LEVEL_W];
            low_in   = product[LEVEL_W-1:0];
            quo_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = alu_borrow ? alu_x[TIME_W-1:0] : alu_res[TIME_W-1:0];
            low_in = {low_ff[LEVEL_W-2:0], 1'b0};
            quo_in = {quo_ff[LEVEL_W-2:0], ~alu_borrow};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         held_ff  <= 1'b0;
         on_ff    <= '0;
         off_ff   <= '0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
         on_ff    <= on_in;
         off_ff   <= off_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff   <= now_in;
      diff_ff  <= diff_in;
      stage_ff <= stage_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      div_d_ff <= div_d_in;
      base_ff  <= base_in;
      sub_ff   <= sub_in;
      rem_ff   <= rem_in;
      low_ff   <= low_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
   end

   assign status.idle      = (state_ff == ST_IDLE);
   assign status.done      = (state_ff == ST_FIN);
   assign result.amplitude = amp_out;
   assign result.stage     = stage_ff;

endmodule

`default_nettype wire

>>> rtl/core/adsr_envelope_generator_unit.sv
// top level of the linear adsr envelope generator
//
// channel   dir   handshake              payload
// req       in    req_tvalid/req_tready  tdata: now, tuser: mode
// rsp       out   rsp_tvalid/rsp_tready  tdata: amplitude, tuser: stage
// csr       in    csr_we                 csr_index, csr_wdata
//
// a 16-step restoring divider forms the ramp quotient of each request
// req_tready is high only while the sequencer is idle
// a finished result waits in the sequencer while the output register is held
// synchronous active-high reset restores register defaults and releases the note
`default_nettype none
`include "assert_macros.svh"

module adsr_envelope_generator_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,   // now
   input  logic [1:0]                     req_tuser,   // mode
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [15:0]                    rsp_tdata,   // amplitude
   output logic [1:0]                     rsp_tuser,   // stage
   input  logic                           csr_we,
   input  logic [adsr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_wdata
);
   import adsr_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   req_type    core_req;
   rsp_type    core_rsp;
   status_type core_status;
   logic       start;
   logic       take;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ATTACK:  cfg_in.attack_time   = csr_wdata;
            CSR_DECAY:   cfg_in.decay_time    = csr_wdata;
            CSR_RELEASE: cfg_in.release_time  = csr_wdata;
            CSR_SUSTAIN: cfg_in.sustain_level = csr_wdata[LEVEL_W-1:0];
            CSR_START:   cfg_in.start_level   = csr_wdata[LEVEL_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_time   <= RST_ATTACK;
         cfg_ff.decay_time    <= RST_DECAY;
         cfg_ff.release_time  <= RST_RELEASE;
         cfg_ff.sustain_level <= RST_SUSTAIN;
         cfg_ff.start_level   <= RST_START;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready    = core_status.idle;
   assign start         = req_tvalid && req_tready;
   assign core_req.mode = req_tuser;
   assign core_req.now  = req_tdata;

   adsr_core u_core (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req    (core_req),
      .cfg    (cfg_ff),
      .take   (take),
      .status (core_status),
      .result (core_rsp)
   );

   // output register
   assign take = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (core_status.done && take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_rsp;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff.amplitude;
   assign rsp_tuser  = rsp_data_ff.stage;

   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)
   `ASSERT_IMPL(a_idle_not_done, clock, reset, req_tready, !core_status.done)
   `ASSERT_IMPL(a_amp_max, clock, reset, rsp_tvalid, rsp_tdata <= LEVEL_ONE)
   `ASSERT_IMPL(a_amp_floor, clock, reset, rsp_tvalid, rsp_tdata == '0 || rsp_tdata > LEVEL_FLOOR)

endmodule

`default_nettype wire

>>> bench/testbench.sv
// testbench of the adsr envelope generator: scoreboard, stream drivers and random note sequences
module testbench;
   import adsr_pkg::*;

   localparam logic [1:0]           MODE_SPARE = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   class envelope_scoreboard;
      cfg_type     settings;
      logic        held;
      logic [31:0] on_t;
      logic [31:0] off_t;
      rsp_type     expected_levels[$];
      int          errors;
      int          requests;
      int          results;

      function new();
         settings.attack_time   = RST_ATTACK;
         settings.decay_time    = RST_DECAY;
         settings.release_time  = RST_RELEASE;
         settings.sustain_level = RST_SUSTAIN;
         settings.start_level   = RST_START;
         held     = 1'b0;
         on_t     = '0;
         off_t    = '0;
         errors   = 0;
         requests = 0;
         results  = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
         case (idx)
            CSR_ATTACK:  settings.attack_time   = data;
            CSR_DECAY:   settings.decay_time    = data;
            CSR_RELEASE: settings.release_time  = data;
            CSR_SUSTAIN: settings.sustain_level = data[LEVEL_W-1:0];
            CSR_START:   settings.start_level   = data[LEVEL_W-1:0];
            default: ;
         endcase
      endfunction

      // a zero duration behaves as one
      function logic [63:0] span_of(logic [31:0] t);
         return (t == '0) ? 64'd1 : 64'(t);
      endfunction

      function logic [63:0] cap_level(logic [LEVEL_W-1:0] v);
         return (v > LEVEL_ONE) ? 64'(LEVEL_ONE) : 64'(v);
      endfunction

      function logic [63:0] ramp(logic [63:0] x, logic [63:0] y, logic [63:0] z);
         return (x * y) / z;
      endfunction

      function void note_request(logic [1:0] mode, logic [31:0] now);
         rsp_type     want;
         logic [63:0] sus;
         logic [63:0] peak;
         logic [63:0] a;
         logic [63:0] d;
         logic [63:0] rt;
         logic [63:0] life;
         logic [63:0] e;
         logic [63:0] amp;
         logic [1:0]  stg;
         requests++;
         sus  = cap_level(settings.sustain_level);
         peak = cap_level(settings.start_level);
         if (mode == MODE_ON) begin
            on_t = now;
            held = 1'b1;
         end else if (mode == MODE_OFF) begin
            off_t = now;
            held  = 1'b0;
         end
         amp = '0;
         if (held) begin
            a = span_of(settings.attack_time);
            d = span_of(settings.decay_time);
            if (now < on_t) begin
               stg = STAGE_ATTACK;
            end else begin
               life = 64'(now) - 64'(on_t);
               if (life <= a) begin
                  amp = ramp(life, peak, a);
                  stg = STAGE_ATTACK;
               end else if (life - a <= d) begin
                  e = life - a;
                  if (sus >= peak) amp = peak + ramp(e, sus - peak, d);
                  else amp = peak - ramp(e, peak - sus, d);
                  stg = STAGE_DECAY;
               end else begin
                  amp = sus;
                  stg = STAGE_SUSTAIN;
               end
            end
         end else begin
            rt  = span_of(settings.release_time);
            stg = STAGE_RELEASE;
            if (now >= off_t) begin
               e = 64'(now) - 64'(off_t);
               amp = (e >= rt) ? 64'd0 : sus - ramp(e, sus, rt);
            end
         end
         // levels near silence are flushed to zero
         if (amp <= 64'(LEVEL_FLOOR)) amp = '0;
         want.amplitude = amp[LEVEL_W-1:0];
         want.stage     = stg;
         expected_levels.push_back(want);
      endfunction

      function void check_response(logic [LEVEL_W-1:0] amp, logic [1:0] stg);
         rsp_type want;
         results++;
         if (expected_levels.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual amplitude %0d stage %0d",
                     $time, amp, stg);
            return;
         end
         want = expected_levels.pop_front();
         if (amp !== want.amplitude) begin
            errors++;
            $display("%0t: amplitude mismatch, expected %0d actual %0d",
                     $time, want.amplitude, amp);
         end
         if (stg !== want.stage) begin
            errors++;
            $display("%0t: stage mismatch, expected %0d actual %0d", $time, want.stage, stg);
         end
      endfunction

      function int pending();
         return expected_levels.size();
      endfunction
   endclass

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [31:0]          req_tdata  = '0;   // now
   logic [1:0]           req_tuser  = '0;   // mode
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;         // amplitude
   logic [1:0]           rsp_tuser;         // stage
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [31:0]          csr_wdata  = '0;

   envelope_scoreboard book;
   int          send_idle   = 7;
   int          recv_idle   = 72;
   int          hold_off    = 0;
   int          phases      = 0;
   logic [31:0] cur_attack  = RST_ATTACK;
   logic [31:0] cur_decay   = RST_DECAY;
   logic [31:0] cur_release = RST_RELEASE;

   adsr_envelope_generator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

   // result side: sample at the falling edge, act at the rising edge
   initial begin
      logic        took;
      logic [15:0] got_amp;
      logic [1:0]  got_stage;
      forever begin
         @(negedge clock);
         took      = rsp_tvalid && rsp_tready && !reset;
         got_amp   = rsp_tdata;
         got_stage = rsp_tuser;
         @(posedge clock);
         if (took) book.check_response(got_amp, got_stage);
         if (hold_off > 0) begin
            hold_off--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   task automatic send_request(input logic [1:0] mode, input logic [31:0] now);
      logic ok;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= now;
      req_tuser  <= mode;
      do begin
         @(negedge clock);
         ok = req_tready;
         @(posedge clock);
      end while (!ok);
      book.note_request(mode, now);
   endtask

   // wait for every outstanding request to be answered, then for the extra idle time asked for
   task automatic settle(input int extra);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (book.pending() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_settings(input logic [31:0] at, input logic [31:0] dc,
                                 input logic [31:0] rl, input logic [31:0] su,
                                 input logic [31:0] st);
      logic [31:0]          vals [6];
      logic [CSR_IDX_W-1:0] idxs [6];
      vals[0] = at;  idxs[0] = CSR_ATTACK;
      vals[1] = dc;  idxs[1] = CSR_DECAY;
      vals[2] = rl;  idxs[2] = CSR_RELEASE;
      vals[3] = su;  idxs[3] = CSR_SUSTAIN;
      vals[4] = st;  idxs[4] = CSR_START;
      vals[5] = $urandom();
      idxs[5] = CSR_UNUSED;
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idxs[i];
         csr_wdata <= vals[i];
         book.write_register(idxs[i], vals[i]);
         @(posedge clock);
      end
      csr_we      <= 1'b0;
      cur_attack  = at;
      cur_decay   = dc;
      cur_release = rl;
      phases++;
   endtask

   function automatic logic [31:0] random_span();
      case ($urandom_range(9))
         0: return 32'd1;
         1: return 32'hFFFF_FFFF;
         2: return 32'd0;
         3, 4, 5, 6: return $urandom_range(2000, 1);
         default: return $urandom_range(200000, 2000);
      endcase
   endfunction

   // upper bits are junk, the block keeps the low sixteen
   function automatic logic [31:0] random_level();
      logic [31:0] junk;
      junk = $urandom() & 32'hFFFF_0000;
      case ($urandom_range(5))
         0: return junk;
         1: return junk | 32'd32768;
         2: return junk | $urandom_range(65535, 32769);
         default: return junk | $urandom_range(32768, 0);
      endcase
   endfunction

   function automatic logic [31:0] jump(input logic [31:0] span);
      logic [31:0] lim;
      lim = (span >> 2) + 32'd2;
      if (lim > 32'h4000_0000) lim = 32'h4000_0000;
      return $urandom_range(lim, 0);
   endfunction

   // note on, samples through the held stages, usually a note off and release samples; now and then a random request
   task automatic run_notes(input int count);
      int          sent;
      int          k;
      logic [31:0] t;
      sent = 0;
      t    = $urandom_range(32'h00FF_FFFF, 0);
      while (sent < count) begin
         if ($urandom_range(9) == 0) begin
            send_request(2'($urandom_range(3)), $urandom());
            sent++;
         end else begin
            send_request(MODE_ON, t);
            sent++;
            k = $urandom_range(8, 1);
            repeat (k) begin
               t += jump($urandom_range(1) ? cur_attack : cur_decay);
               send_request(MODE_SAMPLE, t);
               sent++;
            end
            if ($urandom_range(5) != 0) begin
               t += jump(cur_decay);
               send_request(MODE_OFF, t);
               sent++;
               k = $urandom_range(6, 1);
               repeat (k) begin
                  t += jump(cur_release);
                  send_request(MODE_SAMPLE, t);
                  sent++;
               end
            end
            t += jump(cur_release);
         end
      end
   endtask

   initial begin
      book = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults after reset, release before any note, times before the trigger
      send_request(MODE_SAMPLE, 32'd0);
      send_request(MODE_OFF,    32'd100);
      send_request(MODE_ON,     32'd1000);
      send_request(MODE_SAMPLE, 32'd1327);
      send_request(MODE_SAMPLE, 32'd1655);
      send_request(MODE_SAMPLE, 32'd1656);
      send_request(MODE_SPARE,  32'd30000);
      send_request(MODE_SAMPLE, 32'd67191);
      send_request(MODE_SAMPLE, 32'd67192);
      send_request(MODE_SAMPLE, 32'd500);
      send_request(MODE_OFF,    32'd200000);
      send_request(MODE_SAMPLE, 32'd230000);
      send_request(MODE_SAMPLE, 32'd500000);
      send_request(MODE_SAMPLE, 32'd150000);

      // zero durations, levels above one, top of the time range
      settle(30);
      write_settings(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd40000, 32'h0000_FFFF);
      send_request(MODE_ON,     32'hFFFF_FFF0);
      send_request(MODE_SAMPLE, 32'hFFFF_FFFF);
      send_request(MODE_OFF,    32'hFFFF_FFFF);

      // longest attack
      settle(30);
      write_settings(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd32768);
      send_request(MODE_ON,     32'd0);
      send_request(MODE_SAMPLE, 32'h8000_0000);
      send_request(MODE_SAMPLE, 32'hFFFF_FFFF);

      // rising decay, flush to zero near silence, end of release
      settle(30);
      write_settings(32'd32768, 32'd100, 32'd50, 32'd20000, 32'd1000);
      send_request(MODE_ON,     32'd10);
      send_request(MODE_SAMPLE, 32'd130);
      send_request(MODE_SAMPLE, 32'd150);
      send_request(MODE_SAMPLE, 32'd32828);
      send_request(MODE_SAMPLE, 32'd32978);
      send_request(MODE_OFF,    32'd40000);
      send_request(MODE_SAMPLE, 32'd40025);
      send_request(MODE_SAMPLE, 32'd40050);

      for (int p = 0; p < 12; p++) begin
         settle(30);
         if (p == 4) begin
            send_idle = 72;
            recv_idle = 7;
         end
         if (p == 8) begin
            send_idle = 0;
            recv_idle = 0;
         end
         if (p == 2) write_settings(32'd1, 32'd1, 32'd1, 32'd0, 32'd0);
         else if (p == 6)
            write_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF);
         else if (p == 10) write_settings(32'd0, 32'd0, 32'd0, 32'd32768, 32'd32768);
         else write_settings(random_span(), random_span(), random_span(),
                             random_level(), random_level());
         // long back-pressure so the block fills and stalls its input
         if (p == 1) hold_off = 400;
         run_notes(30);
         if (p == 5) settle(0);
         run_notes(30);
      end

      settle(30);
      $display("sent %0d requests over %0d register settings, checked %0d results",
               book.requests, phases, book.results);
      $display("notes, samples, spare mode, boundary times and back-pressure exercised");
      if (book.errors == 0 && book.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
